[design/tsrmt_pkg.sv]
// shared types and codes for the timestamp reorder match table
// no dependencies
package tsrmt_pkg;

   typedef struct packed {
      logic [63:0] ts;
      logic [31:0] off;
   } entry_type;

   localparam logic [2:0] OP_INSERT   = 3'd0;
   localparam logic [2:0] OP_REMOVE   = 3'd1;
   localparam logic [2:0] OP_DONE_ORD = 3'd2;
   localparam logic [2:0] OP_DONE_OFF = 3'd3;
   localparam logic [2:0] OP_DROP     = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_NO_MATCH = 3'd2;
   localparam logic [2:0] ST_NOT_FND  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   localparam logic signed [31:0] MATCH_WINDOW = 32'sd4096;
   localparam logic [24:0] FIFO_SIZE_RESET = 25'd16777216;

endpackage

[design/tsrmt_mem.sv]
// entry memory: one write port, one read port with registered read data
// depends on tsrmt_pkg
module tsrmt_mem #(
   parameter int DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  tsrmt_pkg::entry_type       wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output tsrmt_pkg::entry_type       rd_data
);
   import tsrmt_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tsrmt_mod.sv]
// restoring remainder unit: 32-bit offset modulo the 25-bit fifo size, one bit a cycle
// depends on tsrmt_pkg for house style only
module tsrmt_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [24:0] divisor,
   output logic        done,
   output logic [31:0] remainder
);
   import tsrmt_pkg::*;

   logic        run_ff, run_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [24:0] dvs_ff, dvs_in;
   logic [24:0] rem_ff, rem_in;
   logic        done_ff, done_in;
   logic [25:0] trial;

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[31]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = 6'd0;
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 25'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[24:0];
         end
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = {7'd0, rem_ff};

`ifndef ASSERT_OFF
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dvs_ff))
      else $error("remainder not below divisor");
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff))
      else $error("done without a running division");
   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> !start)
      else $error("division restarted while running");
`endif

endmodule

[design/timestamp_reorder_match_table_top.sv]
// timestamp reorder match table: control sequencer, table memory and remainder unit
// depends on tsrmt_pkg, tsrmt_mem, tsrmt_mod
//
// An operation is taken when start is high and busy is low; exactly one word comes back on
// rsp_strobe for one cycle and the receiver cannot stall it. Table full, table empty and
// unknown opcodes answer in the next cycle. Every other operation walks the table memory
// once from the head, one entry per cycle through its single read port; an insert into an
// empty table reads no entry. Done by offset first runs the bit-serial remainder unit
// unless fifo_size is zero. A new operation may be started in the cycle its word is shown.
module timestamp_reorder_match_table_top #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [63:0] req_timestamp,
   input  logic signed [31:0] req_stream_offset,
   output logic        rsp_strobe,
   output logic [63:0] rsp_found_timestamp,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_entries_left,
   input  logic        csr_wr_en,
   input  logic [24:0] csr_wr_data
);
   import tsrmt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_MOD, S_WALK} state_type;

   state_type   state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [63:0] ts_ff, ts_in;
   logic [31:0] off_ff, off_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic        dv_ff, dv_in;
   logic [CW-1:0] didx_ff, didx_in;
   logic [CW-1:0] ndel_ff, ndel_in;
   logic        hit_ff, hit_in;
   entry_type   carry_ff, carry_in;
   logic [63:0] found_ff, found_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [24:0] fifo_ff, fifo_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [63:0] rsp_ts_ff, rsp_ts_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [5:0]  rsp_left_ff, rsp_left_in;

   logic        mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type   mem_wdata;
   entry_type   mem_rdata;
   logic        div_start;
   logic        div_done;
   logic [31:0] div_rem;

   logic [31:0] delta;
   logic        in_win;
   logic        too_far;

   tsrmt_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (mem_rdata)
   );

   tsrmt_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_stream_offset),
      .divisor   (fifo_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // signed distance from the entry offset to the searched offset
   assign delta   = off_ff - mem_rdata.off;
   assign in_win  = ($signed(delta) > -MATCH_WINDOW) && ($signed(delta) < MATCH_WINDOW);
   assign too_far = ($signed(delta) > 32'sd0) ||
                    ($signed({delta[31], delta}) < -$signed({9'd0, fifo_ff[24:1]}));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ts_in         = ts_ff;
      off_in        = off_ff;
      rd_ptr_in     = rd_ptr_ff;
      dv_in         = dv_ff;
      didx_in       = didx_ff;
      ndel_in       = ndel_ff;
      hit_in        = hit_ff;
      carry_in      = carry_ff;
      found_in      = found_ff;
      cnt_in        = cnt_ff;
      fifo_in       = csr_wr_en ? csr_wr_data : fifo_ff;
      rsp_strobe_in = 1'b0;
      rsp_ts_in     = rsp_ts_ff;
      rsp_status_in = rsp_status_ff;
      rsp_left_in   = rsp_left_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = carry_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_opcode;
               ts_in     = req_timestamp;
               off_in    = req_stream_offset;
               rd_ptr_in = '0;
               dv_in     = 1'b0;
               ndel_in   = '0;
               hit_in    = 1'b0;
               found_in  = '0;
               rsp_ts_in   = '0;
               rsp_left_in = 6'(cnt_ff);
               unique case (req_opcode) inside
                  OP_INSERT: begin
                     if (cnt_ff == CW'(TABLE_DEPTH)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  OP_REMOVE, OP_DONE_ORD, OP_DONE_OFF, OP_DROP: begin
                     if (cnt_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        unique case (req_opcode)
                           OP_REMOVE:   rsp_status_in = ST_NOT_FND;
                           OP_DONE_OFF: rsp_status_in = ST_NO_MATCH;
                           default:     rsp_status_in = ST_EMPTY;
                        endcase
                     end else if (req_opcode == OP_DONE_OFF && fifo_ff != '0) begin
                        div_start = 1'b1;
                        state_in  = S_MOD;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_MOD: begin
            if (div_done) begin
               off_in   = div_rem;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // keep one read in flight ahead of the entry being handled
            if (rd_ptr_ff != cnt_ff) begin
               rd_ptr_in = rd_ptr_ff + CW'(1);
               dv_in     = 1'b1;
               didx_in   = rd_ptr_ff;
            end else begin
               dv_in = 1'b0;
            end
            if (dv_ff) begin
               if (op_ff == OP_INSERT) begin
                  if (hit_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = didx_ff[AW-1:0];
                     mem_wdata = carry_ff;
                     carry_in  = mem_rdata;
                  end else if (ts_ff <= mem_rdata.ts) begin
                     mem_we    = 1'b1;
                     mem_waddr = didx_ff[AW-1:0];
                     mem_wdata = entry_type'{ts: ts_ff, off: off_ff};
                     carry_in  = mem_rdata;
                     hit_in    = 1'b1;
                  end
               end else begin
                  logic del;
                  del = 1'b0;
                  unique case (op_ff)
                     OP_REMOVE: begin
                        if (!hit_ff && mem_rdata.ts == ts_ff) begin
                           del    = 1'b1;
                           hit_in = 1'b1;
                        end
                     end
                     OP_DONE_OFF: begin
                        if (!hit_ff) begin
                           if (in_win) begin
                              del      = 1'b1;
                              hit_in   = 1'b1;
                              found_in = mem_rdata.ts;
                           end else if (too_far) begin
                              del = 1'b1;
                           end
                        end
                     end
                     default: begin
                        // pop or drop the head
                        if (didx_ff == '0) begin
                           del = 1'b1;
                           if (op_ff == OP_DONE_ORD) begin
                              found_in = mem_rdata.ts;
                           end
                        end
                     end
                  endcase
                  if (del) begin
                     ndel_in = ndel_ff + CW'(1);
                  end else if (ndel_ff != '0) begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(didx_ff - ndel_ff);
                     mem_wdata = mem_rdata;
                  end
               end
            end else if (rd_ptr_ff == cnt_ff) begin
               // walk finished: close out and answer
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_ts_in     = found_ff;
               rsp_status_in = ST_OK;
               if (op_ff == OP_INSERT) begin
                  mem_we    = 1'b1;
                  mem_waddr = cnt_ff[AW-1:0];
                  mem_wdata = hit_ff ? carry_ff : entry_type'{ts: ts_ff, off: off_ff};
                  cnt_in    = cnt_ff + CW'(1);
               end else begin
                  cnt_in = cnt_ff - ndel_ff;
                  if (op_ff == OP_REMOVE && !hit_ff) begin
                     rsp_status_in = ST_NOT_FND;
                  end else if (op_ff == OP_DONE_OFF && !hit_ff) begin
                     rsp_status_in = ST_NO_MATCH;
                  end
               end
               rsp_left_in = 6'(cnt_in);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         fifo_ff       <= FIFO_SIZE_RESET;
         dv_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         fifo_ff       <= fifo_in;
         dv_ff         <= dv_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff         <= op_in;
      ts_ff         <= ts_in;
      off_ff        <= off_in;
      rd_ptr_ff     <= rd_ptr_in;
      didx_ff       <= didx_in;
      ndel_ff       <= ndel_in;
      hit_ff        <= hit_in;
      carry_ff      <= carry_in;
      found_ff      <= found_in;
      rsp_ts_ff     <= rsp_ts_in;
      rsp_status_ff <= rsp_status_in;
      rsp_left_ff   <= rsp_left_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_found_timestamp = rsp_ts_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_entries_left    = rsp_left_ff;

`ifndef ASSERT_OFF
   a_no_write_read_clash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && mem_we && rd_ptr_ff != cnt_ff)
         |-> (mem_waddr != rd_ptr_ff[AW-1:0]))
      else $error("write hits the entry being read");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");
   a_word_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == S_IDLE))
      else $error("word shown while busy");
   a_count_steady_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && $past(state_ff) != S_IDLE) |-> $stable(cnt_ff))
      else $error("entry count moved during a walk");
`endif

endmodule

[sim/tb.sv]
// testbench for timestamp_reorder_match_table_top: queue-fed driver, clocked monitor
// and a table predictor kept in step with every accepted word
// depends on tsrmt_pkg and the design files
`timescale 1ns / 100ps

module tb;
   import tsrmt_pkg::*;

   localparam int DEPTH = 32;
   localparam int DRAIN_CYCLES = 80;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam logic [2:0] OP_BAD_LO = 3'd5;
   localparam logic [2:0] OP_BAD_HI = 3'd7;

   typedef struct {
      logic [2:0]         opcode;
      logic [63:0]        ts;
      logic signed [31:0] off;
   } op_word_type;

   typedef struct {
      logic [63:0] found;
      logic [2:0]  status;
      logic [5:0]  left;
   } table_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start;
   logic busy;
   logic [2:0] req_opcode;
   logic [63:0] req_timestamp;
   logic signed [31:0] req_stream_offset;
   logic rsp_strobe;
   logic [63:0] rsp_found_timestamp;
   logic [2:0] rsp_status;
   logic [5:0] rsp_entries_left;
   logic csr_wr_en = 1'b0;
   logic [24:0] csr_wr_data = '0;

   timestamp_reorder_match_table_top #(.TABLE_DEPTH(DEPTH)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_timestamp(req_timestamp),
      .req_stream_offset(req_stream_offset), .rsp_strobe(rsp_strobe),
      .rsp_found_timestamp(rsp_found_timestamp), .rsp_status(rsp_status),
      .rsp_entries_left(rsp_entries_left), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   op_word_type pending_ops[$];
   table_reply_type expected_replies[$];
   op_word_type cur_op;
   int idle_pct = 0;
   bit failed = 0;
   longint cycles = 0;

   // predicted table contents
   logic [63:0] tbl_ts[DEPTH];
   logic [31:0] tbl_off[DEPTH];
   int tbl_count = 0;
   logic [24:0] fifo_sz = FIFO_SIZE_RESET;

   // recent values so that removes and offset lookups hit stored entries
   logic [63:0] recent_ts[$];
   logic [31:0] recent_off[$];

   task automatic drop_entry(input int pos);
      for (int i = pos; i + 1 < tbl_count; i++) begin
         tbl_ts[i] = tbl_ts[i + 1];
         tbl_off[i] = tbl_off[i + 1];
      end
      tbl_count--;
   endtask

   task automatic apply_table_op(input op_word_type w);
      table_reply_type r;
      int pos;
      logic [31:0] q;
      logic [31:0] diff;
      longint delta, half;
      bit hit;
      r.found = '0;
      r.status = ST_OK;
      case (w.opcode)
         OP_INSERT: begin
            if (tbl_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < tbl_count && !(w.ts <= tbl_ts[pos])) pos++;
               for (int j = tbl_count; j > pos; j--) begin
                  tbl_ts[j] = tbl_ts[j - 1];
                  tbl_off[j] = tbl_off[j - 1];
               end
               tbl_ts[pos] = w.ts;
               tbl_off[pos] = w.off;
               tbl_count++;
            end
         end
         OP_REMOVE: begin
            r.status = ST_NOT_FND;
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl_ts[i] == w.ts) begin
                  drop_entry(i);
                  r.status = ST_OK;
                  break;
               end
            end
         end
         OP_DONE_ORD, OP_DROP: begin
            if (tbl_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (w.opcode == OP_DONE_ORD) r.found = tbl_ts[0];
               drop_entry(0);
            end
         end
         OP_DONE_OFF: begin
            half = longint'(fifo_sz >> 1);
            q = w.off;
            if (fifo_sz != 0) q = q % {7'd0, fifo_sz};
            hit = 0;
            pos = 0;
            while (pos < tbl_count) begin
               diff = q - tbl_off[pos];
               delta = longint'($signed(diff));
               if (delta > -longint'(MATCH_WINDOW) && delta < longint'(MATCH_WINDOW)) begin
                  r.found = tbl_ts[pos];
                  drop_entry(pos);
                  hit = 1;
                  break;
               end
               if (delta > 0 || delta < -half) drop_entry(pos);
               else pos++;
            end
            if (!hit) r.status = ST_NO_MATCH;
         end
         default: ;
      endcase
      r.left = tbl_count[5:0];
      expected_replies.push_back(r);
   endtask

   // driver: one word in flight, held until busy is low
   always @(posedge clock) begin
      bit launch;
      op_word_type nxt;
      if (reset) begin
         start <= 1'b0;
         req_opcode <= '0;
         req_timestamp <= '0;
         req_stream_offset <= '0;
      end else if (!start || !busy) begin
         if (start) apply_table_op(cur_op);
         launch = 0;
         if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
            nxt = pending_ops.pop_front();
            cur_op = nxt;
            launch = 1;
            req_opcode <= nxt.opcode;
            req_timestamp <= nxt.ts;
            req_stream_offset <= nxt.off;
         end
         start <= launch;
      end
   end

   // monitor
   always @(posedge clock) begin
      table_reply_type e;
      if (!reset && rsp_strobe) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected word found=%h status=%0d left=%0d", $time,
                     rsp_found_timestamp, rsp_status, rsp_entries_left);
            failed = 1;
         end else begin
            e = expected_replies.pop_front();
            if (rsp_found_timestamp !== e.found) begin
               $display("%0t: found_timestamp expected %h actual %h", $time, e.found,
                        rsp_found_timestamp);
               failed = 1;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               failed = 1;
            end
            if (rsp_entries_left !== e.left) begin
               $display("%0t: entries_left expected %0d actual %0d", $time, e.left,
                        rsp_entries_left);
               failed = 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic push_op(input logic [2:0] op, input logic [63:0] ts, input logic [31:0] off);
      op_word_type w;
      w.opcode = op;
      w.ts = ts;
      w.off = off;
      pending_ops.push_back(w);
      if (op == OP_INSERT) begin
         recent_ts.push_back(ts);
         recent_off.push_back(off);
         if (recent_ts.size() > 40) begin
            void'(recent_ts.pop_front());
            void'(recent_off.pop_front());
         end
      end
   endtask

   function automatic logic [63:0] pick_ts();
      int k;
      k = $urandom_range(9);
      if (k < 4) return 64'($urandom_range(60));
      if (k < 6 && recent_ts.size() > 0) return recent_ts[$urandom_range(recent_ts.size() - 1)];
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] pick_off(input bit lookup);
      int k;
      logic [31:0] base;
      k = $urandom_range(9);
      if (k == 0) return $urandom;
      if (lookup && recent_off.size() > 0 && k < 8) begin
         base = recent_off[$urandom_range(recent_off.size() - 1)];
         base = base + 32'($signed($urandom_range(10000)) - 5000);
         // same position zero to three wraps further on
         if (k == 7) base = base + {7'd0, fifo_sz} * $urandom_range(3);
         return base;
      end
      if (fifo_sz != 0) return $urandom % {7'd0, fifo_sz};
      return $urandom_range(100000);
   endfunction

   task automatic fill_random(input int n);
      int k;
      for (int i = 0; i < 36; i++) push_op(OP_INSERT, pick_ts(), pick_off(0));
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 38) push_op(OP_INSERT, pick_ts(), pick_off(0));
         else if (k < 50) push_op(OP_REMOVE, pick_ts(), $urandom);
         else if (k < 64) push_op(OP_DONE_ORD, {$urandom, $urandom}, $urandom);
         else if (k < 90) push_op(OP_DONE_OFF, {$urandom, $urandom}, pick_off(1));
         else if (k < 97) push_op(OP_DROP, {$urandom, $urandom}, $urandom);
         else push_op(3'($urandom_range(OP_BAD_HI, OP_BAD_LO)), {$urandom, $urandom}, $urandom);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_ops.size() > 0 || start || expected_replies.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_fifo_size(input logic [24:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      fifo_sz = v;
   endtask

   initial begin
      logic [24:0] sizes[6];
      int pcts[6];
      sizes = '{25'd4096, 25'h1FFFFFF, 25'd0, 25'd100000, 25'd16777216, 25'd0};
      pcts = '{59, 0, 21, 59, 0, 21};
      sizes[5] = 25'($urandom_range(33554431, 4096));
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty table cases, unknown opcodes, field extremes
      push_op(OP_DONE_ORD, '0, '0);
      push_op(OP_DROP, '1, '1);
      push_op(OP_REMOVE, '0, '0);
      push_op(OP_DONE_OFF, '0, 32'hFFFFFFFF);
      push_op(OP_BAD_LO, '1, 32'h80000000);
      push_op(OP_BAD_HI, '0, 32'h7FFFFFFF);
      push_op(OP_INSERT, '0, 32'h7FFFFFFF);
      push_op(OP_INSERT, '1, 32'h80000000);
      push_op(OP_INSERT, 64'd5, 32'd100);
      push_op(OP_INSERT, 64'd5, 32'd200);
      push_op(OP_INSERT, 64'd9, 32'd9000);
      push_op(OP_REMOVE, 64'd5, '0);
      push_op(OP_REMOVE, 64'd6, '0);
      push_op(OP_DONE_OFF, '0, 32'd300);
      push_op(OP_DONE_OFF, '0, 32'h80000010);
      push_op(OP_DONE_ORD, '0, '0);
      push_op(OP_DROP, '0, '0);
      push_op(OP_DONE_OFF, '0, 32'h7FFFFFFF);
      push_op(OP_DONE_ORD, '0, '0);
      fill_random(55);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_fifo_size(sizes[p]);
         idle_pct = pcts[p];
         fill_random(55);
         wait_drained();
      end

      if (!failed) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
design/tsrmt_pkg.sv
design/tsrmt_mem.sv
design/tsrmt_mod.sv
design/timestamp_reorder_match_table_top.sv
sim/tb.sv
